@@ hw/rtl/bfba_pkg.sv @@
// Shared types and constants for the bitmap fixed-size block allocator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bfba_pkg;

  localparam int NUM_BLOCKS_DEF = 64;   // default pool size in blocks
  localparam int ADDR_W         = 32;
  localparam int SIZE_W         = 17;
  localparam int STATUS_W       = 2;
  localparam int MAP_WORD_W     = 32;   // free-map bits per memory word
  localparam int MAP_BIT_W      = $clog2(MAP_WORD_W);
  localparam int QUEUE_DEPTH    = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

  // request action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // classification handed from front to back
  typedef enum logic [1:0] {
    JOB_ALLOC,
    JOB_TOO_LARGE,
    JOB_FREE,
    JOB_BAD_FREE
  } job_kind_t;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_address;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [SIZE_W-1:0] block_size;
  } cfg_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [ADDR_W-1:0] offset;   // address minus base, for frees
  } job_t;

endpackage

`default_nettype wire

@@ hw/rtl/bfba_front.sv @@
// Front end: takes request beats and classifies them into jobs for the back end.
// Depends on bfba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfba_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bfba_pkg::in_item_t in_data,
  input  wire bfba_pkg::cfg_t    cfg,
  input  wire logic              q_full,
  output logic                   push,
  output bfba_pkg::job_t         job
);

  // a beat is taken whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify: oversize check for allocates, zero block size kills any free
  always_comb begin
    job.offset = in_data.address - cfg.base_address;
    if (in_data.action == bfba_pkg::ACT_ALLOC) begin
      if (in_data.request_size > cfg.block_size) begin
        job.kind = bfba_pkg::JOB_TOO_LARGE;
      end else begin
        job.kind = bfba_pkg::JOB_ALLOC;
      end
    end else begin
      if (cfg.block_size == '0) begin
        job.kind = bfba_pkg::JOB_BAD_FREE;
      end else begin
        job.kind = bfba_pkg::JOB_FREE;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bfba_queue.sv @@
// Short job queue between the front and back ends.
// Depends on bfba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfba_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bfba_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output bfba_pkg::job_t      head_job
);

  localparam int DEPTH = bfba_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bfba_pkg::job_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bfba_back.sv @@
// Back end: free-map memory, word scanner, address multiply, free divider and
// the result register. Depends on bfba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfba_back #(
  parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bfba_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire bfba_pkg::job_t  q_job,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output bfba_pkg::out_item_t  out_data
);

  localparam int WORD_W    = bfba_pkg::MAP_WORD_W;
  localparam int BIT_W     = bfba_pkg::MAP_BIT_W;
  localparam int SIZE_W    = bfba_pkg::SIZE_W;
  localparam int ADDR_W    = bfba_pkg::ADDR_W;
  localparam int NW        = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NW > 1) ? $clog2(NW) : 1;
  localparam int IDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int PROD_W    = IDX_W + SIZE_W;
  localparam int TAIL_BITS = NUM_BLOCKS - (NW - 1) * WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL_BITS);
  localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(NW - 1);
  localparam int DIV_CNT_W = $clog2(ADDR_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ADDR_W - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_ADDR,
    S_DIV,
    S_FCHK,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [WA_W-1:0]              w_r, w_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [PROD_W-1:0]            prod_r, prod_nxt;
  logic [SIZE_W-1:0]            rem_r, rem_nxt;
  logic [ADDR_W-1:0]            quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [bfba_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]            res_addr_r, res_addr_nxt;
  logic                         out_valid_r, out_valid_nxt;
  bfba_pkg::out_item_t          out_data_r, out_data_nxt;

  // free map: one bit per block, 1 = free; words never written read as free
  logic [WORD_W-1:0] mem [NW];
  logic [NW-1:0]     vld_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic              wr_en;
  logic [WA_W-1:0]   wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [WORD_W-1:0]     word_mask;
  logic [WORD_W-1:0]     eff_word;
  logic                  any_free;
  logic [BIT_W-1:0]      low_bit;
  logic [WA_W+BIT_W-1:0] scan_idx;
  logic [SIZE_W+1:0]     div_diff;
  logic                  div_ge;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[w_r];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[w_r];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // current word as seen by the scanner, bits past the pool forced used
  assign word_mask = (w_r == LAST_WORD) ? TAIL_MASK : {WORD_W{1'b1}};
  assign eff_word  = (rd_vld_r ? rd_data_r : {WORD_W{1'b1}}) & word_mask;
  assign any_free  = (eff_word != '0);

  // lowest set bit of the word
  always_comb begin
    low_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (eff_word[b]) begin
        low_bit = BIT_W'(b);
      end
    end
  end

  assign scan_idx = {w_r, low_bit};

  // one restoring divide step: offset / block_size, one quotient bit a cycle
  assign div_diff = {1'b0, rem_r, quo_r[ADDR_W-1]} - {2'b00, cfg.block_size};
  assign div_ge   = !div_diff[SIZE_W+1];

  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    idx_nxt        = idx_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    pop            = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = w_r;
    wr_data        = eff_word;

    // result beat taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_job.kind)
            bfba_pkg::JOB_ALLOC: begin
              w_nxt     = '0;
              state_nxt = S_SCAN_RD;
            end
            bfba_pkg::JOB_TOO_LARGE: begin
              res_status_nxt = bfba_pkg::ST_TOO_LARGE;
              res_addr_nxt   = '0;
              state_nxt      = S_DONE;
            end
            bfba_pkg::JOB_FREE: begin
              rem_nxt   = '0;
              quo_nxt   = q_job.offset;
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
            default: begin
              res_status_nxt = bfba_pkg::ST_BAD_FREE;
              res_addr_nxt   = '0;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      // word read in flight
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (any_free) begin
          wr_en     = 1'b1;
          wr_data   = eff_word & ~(WORD_W'(1) << low_bit);
          idx_nxt   = scan_idx[IDX_W-1:0];
          state_nxt = S_MUL;
        end else if (w_r == LAST_WORD) begin
          res_status_nxt = bfba_pkg::ST_FULL;
          res_addr_nxt   = '0;
          state_nxt      = S_DONE;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_MUL: begin
        prod_nxt  = idx_r * cfg.block_size;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        res_status_nxt = bfba_pkg::ST_OK;
        res_addr_nxt   = cfg.base_address + ADDR_W'(prod_r);
        state_nxt      = S_DONE;
      end
      S_DIV: begin
        if (div_ge) begin
          rem_nxt = div_diff[SIZE_W-1:0];
        end else begin
          rem_nxt = {rem_r[SIZE_W-2:0], quo_r[ADDR_W-1]};
        end
        quo_nxt = {quo_r[ADDR_W-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_FCHK;
        end
      end
      // must be on a boundary and inside the pool
      S_FCHK: begin
        if (rem_r != '0 || quo_r >= ADDR_W'(NUM_BLOCKS)) begin
          res_status_nxt = bfba_pkg::ST_BAD_FREE;
          res_addr_nxt   = '0;
          state_nxt      = S_DONE;
        end else begin
          w_nxt     = quo_r[WA_W+BIT_W-1:BIT_W];
          state_nxt = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_WR;
      end
      // block must be in use
      S_FREE_WR: begin
        res_addr_nxt = '0;
        if (eff_word[quo_r[BIT_W-1:0]]) begin
          res_status_nxt = bfba_pkg::ST_BAD_FREE;
        end else begin
          wr_en          = 1'b1;
          wr_data        = eff_word | (WORD_W'(1) << quo_r[BIT_W-1:0]);
          res_status_nxt = bfba_pkg::ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = res_status_r;
          out_data_nxt.block_address = res_addr_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      w_r          <= w_nxt;
      idx_r        <= idx_nxt;
      prod_r       <= prod_nxt;
      rem_r        <= rem_nxt;
      quo_r        <= quo_nxt;
      cnt_r        <= cnt_nxt;
      res_status_r <= res_status_nxt;
      res_addr_r   <= res_addr_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a word is checked only the cycle after its read was issued
  a_scan_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN_CHK |-> $past(state_r) == S_SCAN_RD)
    else $error("scan check without a preceding read");

  // only a good allocate carries an address
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != bfba_pkg::ST_OK |->
      out_data_r.block_address == '0)
    else $error("non-ok result carries an address");

  // a release only touches a block inside the pool on a boundary
  a_free_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FREE_WR |-> quo_r < ADDR_W'(NUM_BLOCKS) && rem_r == '0)
    else $error("release of a block outside the pool");

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_fixed_block_allocator.sv @@
// Top level of the bitmap fixed-size block allocator: config registers and
// the front / queue / back chain. Depends on bfba_pkg and the bfba_* modules.
//
//  channel  direction  handshake          payload
//  in_      request    in_valid/in_stall  bfba_pkg::in_item_t (action, size, address)
//  out_     result     out_valid/out_stall bfba_pkg::out_item_t (status, block_address)
//  cfg_     APB r/w    psel/penable/pwrite base_address @0x0, block_size @0x4
//
// A good allocate scans the 32-bit map words (at most ceil(NUM_BLOCKS/32)) in order,
// then multiplies the found index by the block size and adds the base; a free runs
// the one-bit-per-cycle divider and checks the boundary and pool range before it
// updates the map word. Requests rejected up front go straight to the result.
// Reset marks every block free at once through per-word valid bits; no clearing pass.
// A two-entry job queue keeps taking requests until it is full while the back end
// works or the result register is stalled.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_fixed_block_allocator #(
  parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bfba_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bfba_pkg::out_item_t      out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  localparam logic REG_BASE       = 1'b0;
  localparam logic REG_BLOCK_SIZE = 1'b1;

  logic [bfba_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic [bfba_pkg::SIZE_W-1:0] bsize_r, bsize_nxt;
  bfba_pkg::cfg_t              cfg;
  logic                        cfg_wr;
  logic                        reg_sel;

  logic           push;
  bfba_pkg::job_t push_job;
  logic           q_full;
  logic           pop;
  logic           q_valid;
  bfba_pkg::job_t q_job;

  // config register writes on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    base_nxt  = base_r;
    bsize_nxt = bsize_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_BASE:       base_nxt  = cfg_pwdata;
        REG_BLOCK_SIZE: bsize_nxt = cfg_pwdata[bfba_pkg::SIZE_W-1:0];
        default:        base_nxt  = base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      bsize_r <= bfba_pkg::SIZE_W'(64);
    end else begin
      base_r  <= base_nxt;
      bsize_r <= bsize_nxt;
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_BASE:       cfg_prdata = base_r;
      REG_BLOCK_SIZE: cfg_prdata = 32'(bsize_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.base_address = base_r;
  assign cfg.block_size   = bsize_r;

  bfba_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  bfba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_job   (q_job)
  );

  bfba_back #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ test/bitmap_fixed_block_allocator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_fixed_block_allocator: a queue-fed driver,
// a monitor with a free-map predictor, and APB register writes between phases.
// Depends on bfba_pkg and the allocator RTL.

module bitmap_fixed_block_allocator_tb;

  localparam int NBLK = 64;
  localparam logic [2:0] REG_BASE  = 3'h0;
  localparam logic [2:0] REG_BSIZE = 3'h4;
  localparam int IDLE_GAP    = 48;    // longest back-end job plus slack
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  bfba_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bfba_pkg::out_item_t out_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [2:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  bitmap_fixed_block_allocator #(.NUM_BLOCKS(NBLK)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // shadow of the block: pool registers and one free bit per block
  logic [31:0]     pool_base = '0;
  logic [16:0]     blk_size = 17'd64;
  logic [NBLK-1:0] block_free = '1;

  bfba_pkg::in_item_t  request_q[$];
  bfba_pkg::out_item_t pending_responses[$];
  int                  mismatches = 0;

  logic in_took = 1'b0;
  logic out_took = 1'b0;

  // Expected response to one request; updates the shadow free map.
  function automatic bfba_pkg::out_item_t alloc_response(bfba_pkg::in_item_t req);
    bfba_pkg::out_item_t r;
    logic [31:0] offset;
    logic [63:0] span;
    logic [31:0] idx;
    int          slot;
    r = '0;
    if (req.action == bfba_pkg::ACT_ALLOC) begin
      if (req.request_size > blk_size) begin
        r.status = bfba_pkg::ST_TOO_LARGE;
      end else begin
        slot = -1;
        for (int i = NBLK - 1; i >= 0; i--) if (block_free[i]) slot = i;
        if (slot < 0) begin
          r.status = bfba_pkg::ST_FULL;
        end else begin
          block_free[slot] = 1'b0;
          r.status = bfba_pkg::ST_OK;
          r.block_address = pool_base + 32'(slot) * 32'(blk_size);
        end
      end
    end else begin
      r.status = bfba_pkg::ST_BAD_FREE;
      if (blk_size != 0) begin
        offset = req.address - pool_base;
        span = 64'(NBLK) * 64'(blk_size);
        if (64'(offset) < span && (offset % 32'(blk_size)) == 0) begin
          idx = offset / 32'(blk_size);
          if (!block_free[idx]) begin
            block_free[idx] = 1'b1;
            r.status = bfba_pkg::ST_OK;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, exp_v, act_v);
    mismatches++;
  endfunction

  // Monitor: record accepted beats on both channels, check results in order.
  always @(posedge clk) begin
    in_took  <= rst_n && in_valid && !in_stall;
    out_took <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_responses.size() == 0) begin
          note_mismatch("unexpected result beat", '0, out_data.block_address);
        end else begin
          bfba_pkg::out_item_t want;
          want = pending_responses.pop_front();
          if (out_data.status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(out_data.status));
          if (out_data.block_address !== want.block_address)
            note_mismatch("block_address", want.block_address, out_data.block_address);
        end
      end
      if (in_valid && !in_stall)
        pending_responses.push_back(alloc_response(in_data));
    end
  end

  // Request driver: random gaps per item, with stretches of back-to-back beats.
  int unsigned tx_gap = 0;
  logic        tx_burst = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // beat still stalled: hold payload
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (request_q.size() > 0) begin
      in_data <= request_q.pop_front();
      in_valid <= 1'b1;
      if ($urandom_range(0, 15) == 0) tx_burst <= ~tx_burst;
      tx_gap <= tx_burst ? 0 : $urandom_range(0, 3);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result stall: a fresh stall length is drawn after each accepted result.
  int unsigned rx_hold = 0;
  logic        rx_burst = 1'b0;

  always @(negedge clk) begin
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_took) begin
      if ($urandom_range(0, 15) == 0) rx_burst <= ~rx_burst;
      n = rx_burst ? 0 : $urandom_range(0, 3);
      out_stall <= (n != 0);
      rx_hold <= (n > 0) ? n - 1 : 0;
    end else if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_alloc(input logic [16:0] size);
    bfba_pkg::in_item_t it;
    it = '0;
    it.action = bfba_pkg::ACT_ALLOC;
    it.request_size = size;
    it.address = $urandom();
    request_q.push_back(it);
  endtask

  task automatic push_free(input logic [31:0] addr);
    bfba_pkg::in_item_t it;
    it = '0;
    it.action = bfba_pkg::ACT_FREE;
    it.request_size = 17'($urandom());
    it.address = addr;
    request_q.push_back(it);
  endtask

  // Wait until the sender is empty and every result is back, then settle.
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || pending_responses.size() != 0)
      @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register.
  task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
    logic [31:0] want;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= a;
    cfg_pwdata <= d;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (a == REG_BASE) pool_base = d;
    else blk_size = d[16:0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    want = (a == REG_BASE) ? pool_base : {15'b0, blk_size};
    if (cfg_prdata !== want) note_mismatch("register read back", want, cfg_prdata);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_pool(input logic [31:0] base, input logic [16:0] bsize);
    apb_write(REG_BASE, base);
    apb_write(REG_BSIZE, {15'b0, bsize});
  endtask

  // Random requests: allocates that mostly fit and frees mostly on block boundaries.
  task automatic gen_requests(input int count, input int alloc_pct);
    int          roll;
    int unsigned cap;
    logic [31:0] k;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        cap = (blk_size > 65536) ? 65536 : blk_size;
        if ($urandom_range(0, 15) == 0 && blk_size < 65536)
          push_alloc(17'($urandom_range(blk_size + 1, 65536)));
        else
          push_alloc(17'($urandom_range(0, cap)));
      end else if ($urandom_range(0, 99) < 80) begin
        k = $urandom_range(0, NBLK - 1);
        push_free(pool_base + k * 32'(blk_size));
      end else begin
        case ($urandom_range(0, 2))
          0: push_free($urandom());
          1: push_free(pool_base + 32'(NBLK) * 32'(blk_size));
          default: begin
            k = $urandom_range(0, NBLK - 1);
            push_free(pool_base + k * 32'(blk_size) + 32'($urandom_range(1, 7)));
          end
        endcase
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset pool: base 0, 64-byte blocks
    push_alloc(17'd0);
    push_alloc(17'd64);
    push_alloc(17'd65);            // one byte too large
    push_alloc(17'h10000);
    push_free(32'd0);
    push_free(32'd0);              // double free
    push_free(32'd1);              // off a block boundary
    push_free(32'd4096);           // just past the pool
    push_free(32'hFFFF_FFC0);      // below base, wraps
    push_free(32'hFFFF_FFFF);
    push_alloc(17'd1);
    wait_idle();

    // zero block size
    set_pool(32'h0000_1234, 17'd0);
    push_alloc(17'd0);
    push_alloc(17'd0);
    push_alloc(17'd1);
    push_free(32'h0000_1234);
    wait_idle();

    // widest block size, pool wrapping past the top of the address space
    set_pool(32'hFFFF_0000, 17'h1FFFF);
    push_alloc(17'h10000);
    push_alloc(17'd0);
    push_free(32'hFFFF_0000 + 32'h1FFFF);
    push_free(32'hFFFE_FFFF);
    wait_idle();

    set_pool($urandom(), 17'($urandom_range(1, 256)));
    gen_requests(90, 90);            // drives the pool full
    set_pool(32'hFFFF_FFFF, 17'd1);
    gen_requests(60, 40);
    set_pool($urandom(), 17'd65536);
    gen_requests(70, 55);
    set_pool(32'h0, 17'($urandom_range(1, 65536)));
    gen_requests(60, 50);
    set_pool($urandom(), 17'd3);
    gen_requests(50, 45);
    set_pool(32'hFFF0_0000, 17'h1FFFF);
    gen_requests(60, 55);
    set_pool($urandom(), 17'($urandom_range(1, 4096)));
    gen_requests(40, 60);

    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("** bitmap_fixed_block_allocator: PASSED **");
    end else begin
      $display("** bitmap_fixed_block_allocator: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("** bitmap_fixed_block_allocator: FAILED **");
    $finish;
  end

endmodule

@@ bitmap_fixed_block_allocator.f @@
hw/rtl/bfba_pkg.sv
hw/rtl/bfba_front.sv
hw/rtl/bfba_queue.sv
hw/rtl/bfba_back.sv
hw/rtl/bitmap_fixed_block_allocator.sv
test/bitmap_fixed_block_allocator_tb.sv
